>>> hw/rtl/ced_pkg.sv
// Shared types and constants of the CAN ECU frame decoder.
package ced_pkg;

   localparam int unsigned ReqDataWidth = 136;
   localparam int unsigned RspDataWidth = 72;

   localparam logic [3:0]  MinFrameLen   = 4'd8;
   localparam logic [16:0] CoolantOffset = 17'd50;
   localparam logic [7:0]  MuxRpm        = 8'd0;
   localparam logic [7:0]  MuxCoolant    = 8'd2;

   localparam logic [10:0] TargetIdReset  = 11'd1000;
   localparam logic [15:0] TimeoutMsReset = 16'd500;

   typedef enum logic {
      CSR_TARGET_ID  = 1'b0,
      CSR_TIMEOUT_MS = 1'b1
   } csr_index_type;

   typedef enum logic {
      ACTION_FRAME = 1'b0,
      ACTION_TIME  = 1'b1
   } action_type;

   typedef struct packed {
      action_type  action;
      logic [31:0] now_ms;
      logic [28:0] frame_id;
      logic        frame_extended;
      logic [3:0]  frame_len;
      logic [63:0] frame_data;
   } req_item_type;

   typedef struct packed {
      logic               accepted;
      logic [15:0]        rpm;
      logic               rpm_valid;
      logic signed [16:0] coolant_temp_c;
      logic               coolant_valid;
      logic               any_valid;
      logic [31:0]        frame_count;
   } rsp_item_type;

   typedef struct packed {
      logic        we;
      logic        index;
      logic [15:0] data;
   } csr_write_type;

endpackage

>>> hw/rtl/ced_in_reg.sv
// Input register stage: holds one request beat until the decode stage takes it.
module ced_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  ced_pkg::req_item_type req_item,
   input  logic                  take,
   output logic                  item_valid,
   output ced_pkg::req_item_type item
);

   logic                  valid_ff;
   logic                  valid_in;
   ced_pkg::req_item_type item_ff;
   logic                  load;

   assign req_tready = !valid_ff || take;
   assign load       = req_tvalid && req_tready;
   assign valid_in   = load || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> hw/rtl/ced_core.sv
// Frame filter, stored values with timestamps, freshness check and result build.
module ced_core (
   input  logic                   clock,
   input  logic                   reset,
   input  ced_pkg::csr_write_type csr,
   input  logic                   take,
   input  ced_pkg::req_item_type  item,
   output ced_pkg::rsp_item_type  result
);

   logic [10:0] target_id_ff;
   logic [15:0] timeout_ms_ff;

   logic [15:0] rpm_value_ff, rpm_value_in;
   logic        rpm_seen_ff, rpm_seen_in;
   logic [31:0] rpm_stamp_ff, rpm_stamp_in;
   logic [15:0] coolant_raw_ff, coolant_raw_in;
   logic        coolant_seen_ff, coolant_seen_in;
   logic [31:0] coolant_stamp_ff, coolant_stamp_in;
   logic [31:0] count_ff, count_in;

   logic        match;
   logic [7:0]  mux;
   logic        upd_rpm;
   logic        upd_coolant;
   logic [31:0] rpm_age;
   logic [31:0] coolant_age;
   logic        rpm_valid;
   logic        coolant_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_id_ff  <= ced_pkg::TargetIdReset;
         timeout_ms_ff <= ced_pkg::TimeoutMsReset;
      end else if (csr.we) begin
         unique case (ced_pkg::csr_index_type'(csr.index))
            ced_pkg::CSR_TARGET_ID:  target_id_ff  <= csr.data[10:0];
            ced_pkg::CSR_TIMEOUT_MS: timeout_ms_ff <= csr.data;
            default:                 target_id_ff  <= target_id_ff;
         endcase
      end
   end

   assign mux   = item.frame_data[7:0];
   assign match = (item.action == ced_pkg::ACTION_FRAME) && !item.frame_extended
                  && (item.frame_id == {18'd0, target_id_ff})
                  && (item.frame_len >= ced_pkg::MinFrameLen)
                  && (item.frame_data[15:8] == 8'd0);
   assign upd_rpm     = match && (mux == ced_pkg::MuxRpm);
   assign upd_coolant = match && (mux == ced_pkg::MuxCoolant);

   assign rpm_value_in     = upd_rpm ? item.frame_data[31:16] : rpm_value_ff;
   assign rpm_seen_in      = upd_rpm || rpm_seen_ff;
   assign rpm_stamp_in     = upd_rpm ? item.now_ms : rpm_stamp_ff;
   assign coolant_raw_in   = upd_coolant ? item.frame_data[63:48] : coolant_raw_ff;
   assign coolant_seen_in  = upd_coolant || coolant_seen_ff;
   assign coolant_stamp_in = upd_coolant ? item.now_ms : coolant_stamp_ff;
   assign count_in         = match ? count_ff + 32'd1 : count_ff;

   // A value stored by this very item has age zero, which never exceeds the timeout.
   assign rpm_age       = item.now_ms - rpm_stamp_ff;
   assign coolant_age   = item.now_ms - coolant_stamp_ff;
   assign rpm_valid     = upd_rpm
                          || (rpm_seen_ff && (rpm_age <= {16'd0, timeout_ms_ff}));
   assign coolant_valid = upd_coolant
                          || (coolant_seen_ff && (coolant_age <= {16'd0, timeout_ms_ff}));

   always_ff @(posedge clock) begin
      if (reset) begin
         rpm_value_ff     <= 16'd0;
         rpm_seen_ff      <= 1'b0;
         rpm_stamp_ff     <= 32'd0;
         coolant_raw_ff   <= 16'd0;
         coolant_seen_ff  <= 1'b0;
         coolant_stamp_ff <= 32'd0;
         count_ff         <= 32'd0;
      end else if (take) begin
         rpm_value_ff     <= rpm_value_in;
         rpm_seen_ff      <= rpm_seen_in;
         rpm_stamp_ff     <= rpm_stamp_in;
         coolant_raw_ff   <= coolant_raw_in;
         coolant_seen_ff  <= coolant_seen_in;
         coolant_stamp_ff <= coolant_stamp_in;
         count_ff         <= count_in;
      end
   end

   always_comb begin
      result.accepted       = match;
      result.rpm            = rpm_value_in;
      result.rpm_valid      = rpm_valid;
      result.coolant_temp_c = $signed({1'b0, coolant_raw_in} - ced_pkg::CoolantOffset);
      result.coolant_valid  = coolant_valid;
      result.any_valid      = rpm_valid || coolant_valid;
      result.frame_count    = count_in;
   end

endmodule

>>> hw/rtl/ced_out_reg.sv
// Result register: holds one response beat until the receiver takes it.
module ced_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  ced_pkg::rsp_item_type result,
   output logic                  space,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output ced_pkg::rsp_item_type rsp_item
);

   logic                  valid_ff;
   logic                  valid_in;
   ced_pkg::rsp_item_type item_ff;

   assign space    = !valid_ff || rsp_tready;
   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_item   = item_ff;

endmodule

>>> hw/rtl/can_ecu_frame_decoder_unit.sv
// Top level of the CAN ECU frame decoder: stream ports, stages and beat packing.
//
// Each request beat is either a received CAN frame or a time update, both
// stamped with the current millisecond time. Frames with a standard identifier
// equal to target_id, a length of at least eight and a zero byte 1 are
// accepted; data byte 0 then selects whether rpm (bytes 2-3) or the raw
// coolant word (bytes 6-7) is stored, together with the beat's time. Every
// request beat yields exactly one response beat with the current values,
// their freshness flags and the count of accepted frames.
// A beat passes through an input register and a result register, so the
// response beat is presented from the result register, where a ready
// receiver takes it. One beat is taken every cycle while the receiver keeps
// rsp_tready high; the state update and the result for a beat are formed
// together, in the cycle in which the decode stage passes it on.
// When the receiver stalls, the result register holds its beat and the input
// register can still take one more beat before req_tready falls.
// Reset empties both registers, clears all stored values and the frame count,
// and sets target_id to 1000 and timeout_ms to 500. The csr_ port writes
// a register and should be used only while the block is idle.
module can_ecu_frame_decoder_unit (
   input  logic         clock,
   input  logic         reset,
   // Request stream.
   input  logic         req_tvalid,
   output logic         req_tready,
   // now_ms[31:0], frame_id[60:32], frame_extended[61], frame_len[65:62],
   // frame_data[129:66], zero fill[135:130]
   input  logic [135:0] req_tdata,
   // action[0]
   input  logic         req_tuser,
   // Response stream.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // accepted[0], rpm[16:1], rpm_valid[17], coolant_temp_c[34:18],
   // coolant_valid[35], any_valid[36], frame_count[68:37], zero fill[71:69]
   output logic [71:0]  rsp_tdata,
   // Configuration writes.
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [15:0]  csr_wdata
);

   ced_pkg::req_item_type  req_item;
   ced_pkg::req_item_type  stage_item;
   ced_pkg::rsp_item_type  stage_result;
   ced_pkg::rsp_item_type  rsp_item;
   ced_pkg::csr_write_type csr;
   logic                   stage_valid;
   logic                   out_space;
   logic                   stage_take;

   // Unpack the request beat.
   always_comb begin
      req_item.action         = ced_pkg::action_type'(req_tuser);
      req_item.now_ms         = req_tdata[31:0];
      req_item.frame_id       = req_tdata[60:32];
      req_item.frame_extended = req_tdata[61];
      req_item.frame_len      = req_tdata[65:62];
      req_item.frame_data     = req_tdata[129:66];
   end

   always_comb begin
      csr.we    = csr_we;
      csr.index = csr_index;
      csr.data  = csr_wdata;
   end

   // The decode stage moves its beat on whenever the result register has room.
   assign stage_take = stage_valid && out_space;

   ced_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .take       (stage_take),
      .item_valid (stage_valid),
      .item       (stage_item)
   );

   ced_core u_core (
      .clock  (clock),
      .reset  (reset),
      .csr    (csr),
      .take   (stage_take),
      .item   (stage_item),
      .result (stage_result)
   );

   ced_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (stage_take),
      .result     (stage_result),
      .space      (out_space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   // Pack the response beat, first field in the lowest bits.
   assign rsp_tdata = {3'd0,
                       rsp_item.frame_count,
                       rsp_item.any_valid,
                       rsp_item.coolant_valid,
                       rsp_item.coolant_temp_c,
                       rsp_item.rpm_valid,
                       rsp_item.rpm,
                       rsp_item.accepted};

endmodule
